// ===== src/slcd_pkg.sv =====
// ----------------------------------------------------------------------------
// slcd_pkg: shared types for the sync/length/checksum deframer
// States of the frame parser, the codes of a result item, and the layout of
// a result item.
// ----------------------------------------------------------------------------
package slcd_pkg;

   typedef enum logic [2:0] {
      PH_SYNC1   = 3'd0,
      PH_SYNC2   = 3'd1,
      PH_LEN_HI  = 3'd2,
      PH_LEN_LO  = 3'd3,
      PH_CODE    = 3'd4,
      PH_PAYLOAD = 3'd5,
      PH_CHK_HI  = 3'd6,
      PH_CHK_LO  = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_GOOD    = 2'd1,
      KIND_BAD     = 2'd2,
      KIND_NULL    = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [7:0]  data_code;
      logic        frame_end;
   } result_type;

endpackage

// ===== src/slcd_parser.sv =====
// ----------------------------------------------------------------------------
// slcd_parser: frame parser state machine
// Takes one byte per step, tracks sync, length, code, payload and checksum,
// and gives at most one result item for the byte.
// ----------------------------------------------------------------------------
module slcd_parser import slcd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [7:0]  rx_byte,
   input  logic [7:0]  sync_value,
   output logic        emit,
   output result_type  result
);

   phase_type   phase_ff, phase_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  check_high_ff, check_high_in;
   logic [7:0]  code_ff, code_in;
   logic [15:0] len;
   logic [15:0] rx_check;

   assign len      = remaining_ff | {8'h00, rx_byte};
   assign rx_check = {check_high_ff, rx_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SYNC1;
         remaining_ff  <= '0;
         sum_ff        <= '0;
         check_high_ff <= '0;
         code_ff       <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         remaining_ff  <= remaining_in;
         sum_ff        <= sum_in;
         check_high_ff <= check_high_in;
         code_ff       <= code_in;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      remaining_in  = remaining_ff;
      sum_in        = sum_ff;
      check_high_in = check_high_ff;
      code_in       = code_ff;
      emit          = 1'b0;
      result        = '0;
      case (phase_ff)
         PH_SYNC1: begin
            if (rx_byte == sync_value) phase_in = PH_SYNC2;
         end
         PH_SYNC2: begin
            phase_in = (rx_byte == sync_value) ? PH_LEN_HI : PH_SYNC1;
         end
         PH_LEN_HI: begin
            remaining_in = {rx_byte, 8'h00};
            phase_in     = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            if (len == 16'd0) begin
               remaining_in     = '0;
               phase_in         = PH_SYNC1;
               emit             = 1'b1;
               result.kind      = KIND_NULL;
               result.frame_end = 1'b1;
            end else begin
               remaining_in = len - 16'd1;
               phase_in     = PH_CODE;
            end
         end
         PH_CODE: begin
            code_in  = rx_byte;
            sum_in   = {8'h00, rx_byte};
            phase_in = (remaining_ff == 16'd0) ? PH_CHK_HI : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            sum_in       = sum_ff + {8'h00, rx_byte};
            remaining_in = remaining_ff - 16'd1;
            if (remaining_ff == 16'd1) phase_in = PH_CHK_HI;
            emit             = 1'b1;
            result.kind      = KIND_PAYLOAD;
            result.data_byte = rx_byte;
            result.data_code = code_ff;
         end
         PH_CHK_HI: begin
            check_high_in = rx_byte;
            phase_in      = PH_CHK_LO;
         end
         PH_CHK_LO: begin
            phase_in         = PH_SYNC1;
            emit             = 1'b1;
            result.kind      = (rx_check == sum_ff) ? KIND_GOOD : KIND_BAD;
            result.data_code = code_ff;
            result.frame_end = 1'b1;
         end
         default: begin
            phase_in = PH_SYNC1;
         end
      endcase
   end

endmodule

// ===== src/sync_length_checksum_deframer_top.sv =====
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_top: byte stream frame deframer
// Parses sync, length, code, payload and 16-bit additive checksum frames.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle and sustains one byte per cycle while the
// result side is not stalled by rsp_ready. A byte is latched in the input
// register, parsed by the frame state machine once the result register is free
// or being read, and any result lands in the result register. The state update
// with its 16-bit add and compare sets this rate. Payload bytes come out with
// the frame's data code; the last checksum byte gives good or mismatch, and a
// zero length gives a null frame. csr_write_data sets the sync byte value.
module sync_length_checksum_deframer_top import slcd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [7:0]  rsp_data_code,
   output logic        rsp_frame_end,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);

   logic        in_vld_ff;
   logic [7:0]  in_byte_ff;
   logic        rsp_vld_ff, rsp_vld_in;
   result_type  rsp_ff;
   logic [7:0]  sync_value_ff;
   logic        step;
   logic        emit;
   result_type  result;

   assign step      = in_vld_ff & (~rsp_vld_ff | rsp_ready);
   assign req_ready = ~in_vld_ff | step;

   // hold the sync value
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_value_ff <= '0;
      end else if (csr_write_enable) begin
         sync_value_ff <= csr_write_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   slcd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .rx_byte    (in_byte_ff),
      .sync_value (sync_value_ff),
      .emit       (emit),
      .result     (result)
   );

   // result register
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (step) begin
         rsp_vld_in = emit;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid     = rsp_vld_ff;
   assign rsp_kind      = rsp_ff.kind;
   assign rsp_data_byte = rsp_ff.data_byte;
   assign rsp_data_code = rsp_ff.data_code;
   assign rsp_frame_end = rsp_ff.frame_end;

`ifndef NO_ASSERTIONS
   a_end_matches_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_end == (rsp_kind != KIND_PAYLOAD)))
      else $error("frame_end disagrees with kind");

   a_byte_zero_off_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_PAYLOAD) |-> (rsp_data_byte == 8'h00))
      else $error("data_byte set on a closing result");

   a_null_code_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_NULL) |-> (rsp_data_code == 8'h00))
      else $error("null frame carries a data code");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !step) |=> (in_vld_ff && $stable(in_byte_ff)))
      else $error("stalled input byte lost");
`endif

endmodule
